// ===== hw/rtl/slo_pkg.sv =====
package slo_pkg;

    localparam int EDGE_MAX = 32;
    localparam int CW       = $clog2(EDGE_MAX);
    localparam int ESW      = $clog2(EDGE_MAX + 1);
    localparam int DEPTH    = EDGE_MAX * EDGE_MAX * EDGE_MAX;
    localparam int AW       = $clog2(DEPTH);

    localparam int SIZE_W  = 6;
    localparam int POS_W   = 7;
    localparam int PICK_W  = 16;
    localparam int KIND_W  = 3;
    localparam int VKIND_W = 4;
    localparam int SITE_W  = 6;

    localparam int N_FACE  = 6;
    localparam int N_EDGE  = 12;
    localparam int PIDX_W  = 5;
    localparam int CNT_W   = $clog2(N_EDGE + 1);
    localparam int SEL_W   = $clog2(N_EDGE);

    localparam logic [PIDX_W-1:0] PROBE_CENTER = 5'd0;
    localparam logic [PIDX_W-1:0] PROBE_FACE0  = 5'd1;
    localparam logic [PIDX_W-1:0] PROBE_EDGE0  = 5'd7;
    localparam logic [PIDX_W-1:0] PROBE_LAST   = 5'd18;

    localparam logic [2:0] OP_QUERY  = 3'd0;
    localparam logic [2:0] OP_PLACE  = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_BORDER = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BORDER   = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_NO_SITE  = 2'd3;

    localparam logic [VKIND_W-1:0] KIND_EMPTY  = 4'd0;
    localparam logic [VKIND_W-1:0] KIND_BORDER = 4'd8;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd31;

    typedef struct packed {
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
    } sizes_t;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } ofs_t;

    // probe 0 is the addressed voxel, 1..6 faces, 7..18 edge neighbours
    function automatic ofs_t probe_ofs(input logic [PIDX_W-1:0] idx);
        ofs_t o;
        case (idx)
            5'd1:    o = '{2'b11, 2'b00, 2'b00};
            5'd2:    o = '{2'b00, 2'b11, 2'b00};
            5'd3:    o = '{2'b00, 2'b00, 2'b11};
            5'd4:    o = '{2'b01, 2'b00, 2'b00};
            5'd5:    o = '{2'b00, 2'b01, 2'b00};
            5'd6:    o = '{2'b00, 2'b00, 2'b01};
            5'd7:    o = '{2'b11, 2'b00, 2'b11};
            5'd8:    o = '{2'b11, 2'b00, 2'b01};
            5'd9:    o = '{2'b01, 2'b00, 2'b11};
            5'd10:   o = '{2'b01, 2'b00, 2'b01};
            5'd11:   o = '{2'b11, 2'b11, 2'b00};
            5'd12:   o = '{2'b11, 2'b01, 2'b00};
            5'd13:   o = '{2'b01, 2'b11, 2'b00};
            5'd14:   o = '{2'b01, 2'b01, 2'b00};
            5'd15:   o = '{2'b00, 2'b11, 2'b11};
            5'd16:   o = '{2'b00, 2'b11, 2'b01};
            5'd17:   o = '{2'b00, 2'b01, 2'b11};
            5'd18:   o = '{2'b00, 2'b01, 2'b01};
            default: o = '{2'b00, 2'b00, 2'b00};
        endcase
        return o;
    endfunction

endpackage

// ===== hw/rtl/slo_store.sv =====
module slo_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [slo_pkg::AW-1:0]          raddr,
    input  logic                            we,
    input  logic [slo_pkg::AW-1:0]          waddr,
    input  logic [slo_pkg::KIND_W-1:0]      wdata,
    output logic [slo_pkg::KIND_W-1:0]      rd_data,
    output logic                            clr_busy
);

    logic [slo_pkg::KIND_W-1:0] mem [slo_pkg::DEPTH];

    logic [slo_pkg::AW-1:0]     clr_cnt_reg;
    logic [slo_pkg::AW-1:0]     clr_cnt_next;
    logic                       clr_busy_reg;
    logic                       clr_busy_next;
    logic                       mem_we;
    logic [slo_pkg::AW-1:0]     mem_waddr;
    logic [slo_pkg::KIND_W-1:0] mem_wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == slo_pkg::AW'(slo_pkg::DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
        mem_we    = clr_busy_reg ? 1'b1 : we;
        mem_waddr = clr_busy_reg ? clr_cnt_reg : waddr;
        mem_wdata = clr_busy_reg ? '0 : wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[raddr];
    end

    assign clr_busy = clr_busy_reg;

endmodule

// ===== hw/rtl/slo_probe.sv =====
module slo_probe (
    input  logic                               clk,
    input  slo_pkg::sizes_t                    sizes,
    input  logic signed [slo_pkg::POS_W-1:0]   base_x,
    input  logic signed [slo_pkg::POS_W-1:0]   base_y,
    input  logic signed [slo_pkg::POS_W-1:0]   base_z,
    input  logic [slo_pkg::PIDX_W-1:0]         idx,
    output logic [slo_pkg::AW-1:0]             addr,
    output logic                               border_q
);

    localparam int SQW = 2 * slo_pkg::CW;
    localparam int SUW = SQW + 2;

    slo_pkg::ofs_t              ofs;
    logic [slo_pkg::ESW-1:0]    ex, ey, ez;
    logic signed [7:0]          x, y, z;
    logic                       inbox;
    logic [slo_pkg::CW-1:0]     xu, yu, zu;
    logic [slo_pkg::CW-1:0]     cx, cy, cz;
    logic [slo_pkg::CW-1:0]     ax, ay, az;
    logic [SQW-1:0]             sqx, sqy, sqz, rr;
    logic [SUW-1:0]             dsq;

    function automatic logic [slo_pkg::ESW-1:0] eff(input logic [slo_pkg::SIZE_W-1:0] s);
        return (int'(s) > slo_pkg::EDGE_MAX) ? slo_pkg::ESW'(slo_pkg::EDGE_MAX)
                                             : slo_pkg::ESW'(s);
    endfunction

    function automatic logic [slo_pkg::CW-1:0] ctr(input logic [slo_pkg::ESW-1:0] e);
        logic [slo_pkg::ESW-1:0] m;
        m = e - 1'b1;
        return slo_pkg::CW'(m >> 1);
    endfunction

    always_comb
    begin
        ofs = slo_pkg::probe_ofs(idx);
        ex  = eff(sizes.sx);
        ey  = eff(sizes.sy);
        ez  = eff(sizes.sz);
        x   = {base_x[slo_pkg::POS_W-1], base_x} + {{6{ofs.dx[1]}}, ofs.dx};
        y   = {base_y[slo_pkg::POS_W-1], base_y} + {{6{ofs.dy[1]}}, ofs.dy};
        z   = {base_z[slo_pkg::POS_W-1], base_z} + {{6{ofs.dz[1]}}, ofs.dz};
        inbox = !x[7] && !y[7] && !z[7]
             && (8'(x) < 8'(ex)) && (8'(y) < 8'(ey)) && (8'(z) < 8'(ez));
        xu = x[slo_pkg::CW-1:0];
        yu = y[slo_pkg::CW-1:0];
        zu = z[slo_pkg::CW-1:0];
        cx = ctr(ex);
        cy = ctr(ey);
        cz = ctr(ez);
        ax = (xu >= cx) ? xu - cx : cx - xu;
        ay = (yu >= cy) ? yu - cy : cy - yu;
        az = (zu >= cz) ? zu - cz : cz - zu;
        sqx  = SQW'(ax) * SQW'(ax);
        sqy  = SQW'(ay) * SQW'(ay);
        sqz  = SQW'(az) * SQW'(az);
        rr   = SQW'(cx) * SQW'(cx);
        dsq  = SUW'(sqx) + SUW'(sqy) + SUW'(sqz);
        addr = slo_pkg::AW'(slo_pkg::AW'(xu) * slo_pkg::AW'(slo_pkg::EDGE_MAX * slo_pkg::EDGE_MAX)
             + slo_pkg::AW'(yu) * slo_pkg::AW'(slo_pkg::EDGE_MAX) + slo_pkg::AW'(zu));
    end

    always_ff @(posedge clk)
    begin
        border_q <= !inbox || (dsq > SUW'(rr));
    end

endmodule

// ===== hw/rtl/slo_mod.sv =====
module slo_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [slo_pkg::PICK_W-1:0]    dividend,
    input  logic [slo_pkg::CNT_W-1:0]     divisor,
    output logic                          done,
    output logic [slo_pkg::CNT_W-1:0]     rem
);

    localparam int STEP_W = $clog2(slo_pkg::PICK_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            cnt_reg, cnt_next;
    logic [slo_pkg::PICK_W-1:0]   dvd_reg, dvd_next;
    logic [slo_pkg::CNT_W-1:0]    div_reg, div_next;
    logic [slo_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [slo_pkg::CNT_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[slo_pkg::PICK_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, div_reg}) ? slo_pkg::CNT_W'(trial - {1'b0, div_reg})
                                                  : slo_pkg::CNT_W'(trial);
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(slo_pkg::PICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/sphere_lattice_occupancy_engine.sv =====
// Voxel reads per request: query/place/remove 1, border test 7, find division site 19 (pipelined
// reads); a find then takes the pick remainder and selects among up to 12 candidate sites.
// Throughput: one request at a time; the next request is taken once the last is handed
// to the output register. Set by the single store read port and the shared remainder unit.
// Reset: sizes go to 31; the store is then cleared one voxel a cycle, all 32768 voxels,
// with in_stall high meanwhile. Config writes are taken at any time.
module sphere_lattice_occupancy_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           opcode,
    input  logic signed [slo_pkg::POS_W-1:0]     pos_x,
    input  logic signed [slo_pkg::POS_W-1:0]     pos_y,
    input  logic signed [slo_pkg::POS_W-1:0]     pos_z,
    input  logic [slo_pkg::KIND_W-1:0]           occupant_kind,
    input  logic [slo_pkg::PICK_W-1:0]           pick,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [slo_pkg::VKIND_W-1:0]          voxel_kind,
    output logic [1:0]                           status,
    output logic signed [slo_pkg::SITE_W-1:0]    site_x,
    output logic signed [slo_pkg::SITE_W-1:0]    site_y,
    output logic signed [slo_pkg::SITE_W-1:0]    site_z,
    output logic                                 touches_border,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [slo_pkg::SIZE_W-1:0]           cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_MOD    = 7'b0010000,
        S_SEL    = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    localparam int PW = slo_pkg::POS_W;
    localparam int SW = slo_pkg::SITE_W;
    localparam logic [SW-1:0] SITE_NONE = {SW{1'b1}};

    state_t                          state_reg, state_next;
    slo_pkg::sizes_t                 sizes_reg, sizes_next;
    logic [2:0]                      op_reg, op_next;
    logic signed [PW-1:0]            px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [slo_pkg::KIND_W-1:0]      kin_reg, kin_next;
    logic [slo_pkg::PICK_W-1:0]      pick_reg, pick_next;
    logic [slo_pkg::PIDX_W-1:0]      idx_reg, idx_next, last_reg, last_next;
    logic                            ev_vld_reg, ev_vld_next;
    logic [slo_pkg::PIDX_W-1:0]      ev_idx_reg, ev_idx_next;
    logic [slo_pkg::VKIND_W-1:0]     ckind_reg, ckind_next;
    logic [slo_pkg::N_FACE-1:0]      face_reg, face_next;
    logic [slo_pkg::N_EDGE-1:0]      edge_reg, edge_next;
    logic                            touch_reg, touch_next;
    logic [slo_pkg::N_EDGE-1:0]      mask_reg, mask_next;
    logic                            esel_reg, esel_next;
    logic [slo_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [slo_pkg::SEL_W-1:0]       j_reg, j_next;
    logic [1:0]                      rst_reg, rst_next;
    logic [SW-1:0]                   rsx_reg, rsx_next, rsy_reg, rsy_next, rsz_reg, rsz_next;

    logic                            ov_reg, ov_next;
    logic [slo_pkg::VKIND_W-1:0]     o_kind_reg, o_kind_next;
    logic [1:0]                      o_st_reg, o_st_next;
    logic [SW-1:0]                   o_sx_reg, o_sx_next, o_sy_reg, o_sy_next;
    logic [SW-1:0]                   o_sz_reg, o_sz_next;
    logic                            o_tb_reg, o_tb_next;

    logic [slo_pkg::AW-1:0]          rd_addr, wr_addr_reg, wr_addr_next;
    logic                            border_q;
    logic [slo_pkg::KIND_W-1:0]      rd_data;
    logic                            clr_busy;
    logic [slo_pkg::VKIND_W-1:0]     kind_q;
    logic                            st_we;
    logic [slo_pkg::KIND_W-1:0]      st_wdata;
    logic                            dm_start, dm_done;
    logic [slo_pkg::CNT_W-1:0]       dm_count, dm_rem;
    logic [slo_pkg::PIDX_W-1:0]      probe_idx;
    logic                            accept, out_free;
    slo_pkg::ofs_t                   sofs;
    logic [7:0]                      sxw, syw, szw;

    slo_probe u_probe (
        .clk      (clk),
        .sizes    (sizes_reg),
        .base_x   (px_reg),
        .base_y   (py_reg),
        .base_z   (pz_reg),
        .idx      (probe_idx),
        .addr     (rd_addr),
        .border_q (border_q)
    );

    slo_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .raddr    (rd_addr),
        .we       (st_we),
        .waddr    (wr_addr_reg),
        .wdata    (st_wdata),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    slo_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dm_start),
        .dividend (pick_reg),
        .divisor  (dm_count),
        .done     (dm_done),
        .rem      (dm_rem)
    );

    assign in_stall  = (state_reg != S_IDLE) || clr_busy;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !ov_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign kind_q    = border_q ? slo_pkg::KIND_BORDER : {1'b0, rd_data};
    assign probe_idx = idx_reg;

    always_comb
    begin
        sofs = slo_pkg::probe_ofs(slo_pkg::PIDX_W'((esel_reg ? slo_pkg::PROBE_EDGE0
                                                           : slo_pkg::PROBE_FACE0)
                                               + slo_pkg::PIDX_W'(j_reg)));
        sxw  = {px_reg[PW-1], px_reg} + {{6{sofs.dx[1]}}, sofs.dx};
        syw  = {py_reg[PW-1], py_reg} + {{6{sofs.dy[1]}}, sofs.dy};
        szw  = {pz_reg[PW-1], pz_reg} + {{6{sofs.dz[1]}}, sofs.dz};
    end

    always_comb
    begin
        state_next   = state_reg;
        sizes_next   = sizes_reg;
        op_next      = op_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        kin_next     = kin_reg;
        pick_next    = pick_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        ev_vld_next  = (state_reg == S_SCAN);
        ev_idx_next  = idx_reg;
        ckind_next   = ckind_reg;
        face_next    = face_reg;
        edge_next    = edge_reg;
        touch_next   = touch_reg;
        mask_next    = mask_reg;
        esel_next    = esel_reg;
        rem_next     = rem_reg;
        j_next       = j_reg;
        rst_next     = rst_reg;
        rsx_next     = rsx_reg;
        rsy_next     = rsy_reg;
        rsz_next     = rsz_reg;
        wr_addr_next = wr_addr_reg;
        ov_next      = ov_reg;
        o_kind_next  = o_kind_reg;
        o_st_next    = o_st_reg;
        o_sx_next    = o_sx_reg;
        o_sy_next    = o_sy_reg;
        o_sz_next    = o_sz_reg;
        o_tb_next    = o_tb_reg;
        st_we        = 1'b0;
        st_wdata     = kin_reg;
        dm_start     = 1'b0;
        dm_count     = slo_pkg::CNT_W'($countones(face_reg));

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slo_pkg::CFG_SIZE_X: sizes_next.sx = cfg_data;
                slo_pkg::CFG_SIZE_Y: sizes_next.sy = cfg_data;
                slo_pkg::CFG_SIZE_Z: sizes_next.sz = cfg_data;
                default:             sizes_next    = sizes_reg;
            endcase
        end

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (ev_vld_reg)
        begin
            if (ev_idx_reg == slo_pkg::PROBE_CENTER)
            begin
                ckind_next = kind_q;
            end
            for (int i = 0; i < slo_pkg::N_FACE; i++)
            begin
                if (ev_idx_reg == slo_pkg::PIDX_W'(slo_pkg::PROBE_FACE0 + i))
                begin
                    face_next[i] = (kind_q == slo_pkg::KIND_EMPTY);
                    if (kind_q == slo_pkg::KIND_BORDER)
                    begin
                        touch_next = 1'b1;
                    end
                end
            end
            for (int i = 0; i < slo_pkg::N_EDGE; i++)
            begin
                if (ev_idx_reg == slo_pkg::PIDX_W'(slo_pkg::PROBE_EDGE0 + i))
                begin
                    edge_next[i] = (kind_q == slo_pkg::KIND_EMPTY);
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    px_next    = pos_x;
                    py_next    = pos_y;
                    pz_next    = pos_z;
                    kin_next   = occupant_kind;
                    pick_next  = pick;
                    idx_next   = slo_pkg::PROBE_CENTER;
                    face_next  = '0;
                    edge_next  = '0;
                    touch_next = 1'b0;
                    ckind_next = slo_pkg::KIND_EMPTY;
                    rst_next   = slo_pkg::ST_DONE;
                    rsx_next   = SITE_NONE;
                    rsy_next   = SITE_NONE;
                    rsz_next   = SITE_NONE;
                    if (opcode == slo_pkg::OP_FIND)
                    begin
                        last_next = slo_pkg::PROBE_LAST;
                    end
                    else if (opcode == slo_pkg::OP_BORDER)
                    begin
                        last_next = slo_pkg::PIDX_W'(slo_pkg::PROBE_FACE0 + slo_pkg::N_FACE - 1);
                    end
                    else
                    begin
                        last_next = slo_pkg::PROBE_CENTER;
                    end
                    if (opcode > slo_pkg::OP_BORDER)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg == slo_pkg::PROBE_CENTER)
                begin
                    wr_addr_next = rd_addr;
                end
                if (idx_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_FIN;
                case (op_reg)
                    slo_pkg::OP_QUERY:
                    begin
                        rst_next = (ckind_reg == slo_pkg::KIND_BORDER) ? slo_pkg::ST_BORDER
                                                                       : slo_pkg::ST_DONE;
                    end
                    slo_pkg::OP_PLACE:
                    begin
                        if (ckind_reg == slo_pkg::KIND_BORDER)
                        begin
                            rst_next = slo_pkg::ST_BORDER;
                        end
                        else if (ckind_reg != slo_pkg::KIND_EMPTY)
                        begin
                            rst_next = slo_pkg::ST_OCCUPIED;
                        end
                        else
                        begin
                            st_we = 1'b1;
                        end
                    end
                    slo_pkg::OP_REMOVE:
                    begin
                        if (ckind_reg == slo_pkg::KIND_BORDER)
                        begin
                            rst_next = slo_pkg::ST_BORDER;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_wdata = '0;
                        end
                    end
                    slo_pkg::OP_FIND:
                    begin
                        if (face_reg != '0)
                        begin
                            mask_next  = slo_pkg::N_EDGE'(face_reg);
                            esel_next  = 1'b0;
                            dm_start   = 1'b1;
                            state_next = S_MOD;
                        end
                        else if (edge_reg != '0)
                        begin
                            mask_next  = edge_reg;
                            esel_next  = 1'b1;
                            dm_count   = slo_pkg::CNT_W'($countones(edge_reg));
                            dm_start   = 1'b1;
                            state_next = S_MOD;
                        end
                        else
                        begin
                            rst_next = slo_pkg::ST_NO_SITE;
                        end
                    end
                    default:
                    begin
                        rst_next = slo_pkg::ST_DONE;
                    end
                endcase
            end
            S_MOD:
            begin
                if (dm_done)
                begin
                    rem_next   = dm_rem;
                    j_next     = '0;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                j_next = j_reg + 1'b1;
                if (mask_reg[j_reg])
                begin
                    if (rem_reg == '0)
                    begin
                        rsx_next   = sxw[SW-1:0];
                        rsy_next   = syw[SW-1:0];
                        rsz_next   = szw[SW-1:0];
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_kind_next = (op_reg > slo_pkg::OP_BORDER) ? slo_pkg::KIND_EMPTY
                                                                : ckind_reg;
                    o_st_next   = rst_reg;
                    o_sx_next   = rsx_reg;
                    o_sy_next   = rsy_reg;
                    o_sz_next   = rsz_reg;
                    o_tb_next   = (op_reg == slo_pkg::OP_BORDER) && touch_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sizes_reg  <= '{slo_pkg::SIZE_RESET, slo_pkg::SIZE_RESET, slo_pkg::SIZE_RESET};
            ev_vld_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sizes_reg  <= sizes_next;
            ev_vld_reg <= ev_vld_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        kin_reg     <= kin_next;
        pick_reg    <= pick_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        ev_idx_reg  <= ev_idx_next;
        ckind_reg   <= ckind_next;
        face_reg    <= face_next;
        edge_reg    <= edge_next;
        touch_reg   <= touch_next;
        mask_reg    <= mask_next;
        esel_reg    <= esel_next;
        rem_reg     <= rem_next;
        j_reg       <= j_next;
        rst_reg     <= rst_next;
        rsx_reg     <= rsx_next;
        rsy_reg     <= rsy_next;
        rsz_reg     <= rsz_next;
        wr_addr_reg <= wr_addr_next;
        o_kind_reg  <= o_kind_next;
        o_st_reg    <= o_st_next;
        o_sx_reg    <= o_sx_next;
        o_sy_reg    <= o_sy_next;
        o_sz_reg    <= o_sz_next;
        o_tb_reg    <= o_tb_next;
    end

    assign out_valid      = ov_reg;
    assign voxel_kind     = o_kind_reg;
    assign status         = o_st_reg;
    assign site_x         = o_sx_reg;
    assign site_y         = o_sy_reg;
    assign site_z         = o_sz_reg;
    assign touches_border = o_tb_reg;

endmodule

// ===== hw/rtl/slo_checker.sv =====
module slo_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [slo_pkg::VKIND_W-1:0]          voxel_kind,
    input  logic [1:0]                           status,
    input  logic signed [slo_pkg::SITE_W-1:0]    site_x,
    input  logic signed [slo_pkg::SITE_W-1:0]    site_y,
    input  logic signed [slo_pkg::SITE_W-1:0]    site_z,
    input  logic                                 touches_border
);

    localparam logic [slo_pkg::SITE_W-1:0] NONE = {slo_pkg::SITE_W{1'b1}};

    // one request in flight
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while a request is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(voxel_kind) && $stable(status)
                                      && $stable(site_x) && $stable(touches_border)))
        else $error("stalled result changed");

    a_no_site: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == slo_pkg::ST_NO_SITE)
        |-> (site_x == NONE && site_y == NONE && site_z == NONE && !touches_border))
        else $error("no-site result carries a site");

    a_touch_only_test: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && touches_border)
        |-> (status == slo_pkg::ST_DONE && site_x == NONE && site_y == NONE))
        else $error("touches_border on a non border-test result");

    a_occupied_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == slo_pkg::ST_OCCUPIED)
        |-> (voxel_kind != slo_pkg::KIND_EMPTY && voxel_kind != slo_pkg::KIND_BORDER))
        else $error("occupied status with empty or border kind");

endmodule

bind sphere_lattice_occupancy_engine slo_checker u_slo_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .voxel_kind     (voxel_kind),
    .status         (status),
    .site_x         (site_x),
    .site_y         (site_y),
    .site_z         (site_z),
    .touches_border (touches_border)
);

// ===== tb/sphere_lattice_occupancy_engine_tb.sv =====
module sphere_lattice_occupancy_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slo_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         SHOW_LIMIT  = 40;

    typedef struct {
        logic [2:0]          op;
        logic signed [6:0]   x;
        logic signed [6:0]   y;
        logic signed [6:0]   z;
        logic [KIND_W-1:0]   kind;
        logic [PICK_W-1:0]   pick;
    } lattice_req_t;

    typedef struct {
        logic [VKIND_W-1:0]  vkind;
        logic [1:0]          st;
        logic [SITE_W-1:0]   sx;
        logic [SITE_W-1:0]   sy;
        logic [SITE_W-1:0]   sz;
        logic                touch;
    } lattice_rsp_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [2:0]                 opcode = '0;
    logic signed [POS_W-1:0]    pos_x = '0;
    logic signed [POS_W-1:0]    pos_y = '0;
    logic signed [POS_W-1:0]    pos_z = '0;
    logic [KIND_W-1:0]          occupant_kind = '0;
    logic [PICK_W-1:0]          pick = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [VKIND_W-1:0]         voxel_kind;
    logic [1:0]                 status;
    logic signed [SITE_W-1:0]   site_x;
    logic signed [SITE_W-1:0]   site_y;
    logic signed [SITE_W-1:0]   site_z;
    logic                       touches_border;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [SIZE_W-1:0]          cfg_data = '0;

    // face neighbours first, then edge neighbours, in search order
    int nb_dx [18] = '{-1, 0, 0, 1, 0, 0, -1, -1, 1, 1, -1, -1, 1, 1, 0, 0, 0, 0};
    int nb_dy [18] = '{0, -1, 0, 0, 1, 0, 0, 0, 0, 0, -1, 1, -1, 1, -1, -1, 1, 1};
    int nb_dz [18] = '{0, 0, -1, 0, 0, 1, -1, 1, -1, 1, 0, 0, 0, 0, -1, 1, -1, 1};

    logic [KIND_W-1:0]  occ_model [DEPTH];
    logic [SIZE_W-1:0]  lat_size [3] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};

    lattice_req_t pending_reqs [$];
    lattice_rsp_t expected_rsps [$];
    lattice_req_t req_now;
    lattice_rsp_t rsp_due;

    int  unaccepted = 0;
    int  errors = 0;
    int  results_seen = 0;
    int  finds_no_site = 0;
    int  border_hits = 0;
    int  settings_used = 1;
    int  op_seen [8];
    bit  calm = 1'b0;
    bit  slot_free;

    sphere_lattice_occupancy_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .occupant_kind  (occupant_kind),
        .pick           (pick),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .voxel_kind     (voxel_kind),
        .status         (status),
        .site_x         (site_x),
        .site_y         (site_y),
        .site_z         (site_z),
        .touches_border (touches_border),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #24_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clip(logic [SIZE_W-1:0] s);
        return (s > EDGE_MAX) ? EDGE_MAX : int'(s);
    endfunction

    function automatic bit off_lattice(int x, int y, int z);
        int ex = clip(lat_size[CFG_SIZE_X]);
        int ey = clip(lat_size[CFG_SIZE_Y]);
        int ez = clip(lat_size[CFG_SIZE_Z]);
        int rad = (ex - 1) / 2;
        int cx = (ex - 1) / 2;
        int cy = (ey - 1) / 2;
        int cz = (ez - 1) / 2;
        if (x < 0 || x >= ex || y < 0 || y >= ey || z < 0 || z >= ez)
            return 1'b1;
        return (x - cx) * (x - cx) + (y - cy) * (y - cy) + (z - cz) * (z - cz) > rad * rad;
    endfunction

    function automatic int cell_addr(int x, int y, int z);
        return (x * EDGE_MAX + y) * EDGE_MAX + z;
    endfunction

    function automatic logic [VKIND_W-1:0] kind_at(int x, int y, int z);
        if (off_lattice(x, y, z))
            return KIND_BORDER;
        return {1'b0, occ_model[cell_addr(x, y, z)]};
    endfunction

    function automatic lattice_rsp_t apply_request(lattice_req_t r);
        lattice_rsp_t o;
        int x = r.x;
        int y = r.y;
        int z = r.z;
        int hits [12];
        int n;
        int sel;
        bit found;
        o.vkind = KIND_EMPTY;
        o.st = ST_DONE;
        o.sx = '1;
        o.sy = '1;
        o.sz = '1;
        o.touch = 1'b0;
        if (r.op <= OP_BORDER)
            o.vkind = kind_at(x, y, z);
        case (r.op)
            OP_QUERY:
            begin
                if (o.vkind == KIND_BORDER)
                    o.st = ST_BORDER;
            end
            OP_PLACE:
            begin
                if (o.vkind == KIND_BORDER)
                    o.st = ST_BORDER;
                else if (o.vkind != KIND_EMPTY)
                    o.st = ST_OCCUPIED;
                else
                    occ_model[cell_addr(x, y, z)] = r.kind;
            end
            OP_REMOVE:
            begin
                if (o.vkind == KIND_BORDER)
                    o.st = ST_BORDER;
                else
                    occ_model[cell_addr(x, y, z)] = '0;
            end
            OP_FIND:
            begin
                found = 1'b0;
                for (int grp = 0; grp < 2; grp++)
                begin
                    if (!found)
                    begin
                        n = 0;
                        for (int i = grp * N_FACE; i < (grp == 0 ? N_FACE : N_FACE + N_EDGE); i++)
                        begin
                            if (kind_at(x + nb_dx[i], y + nb_dy[i], z + nb_dz[i]) == KIND_EMPTY)
                            begin
                                hits[n] = i;
                                n++;
                            end
                        end
                        if (n > 0)
                        begin
                            sel = hits[int'(r.pick) % n];
                            found = 1'b1;
                            o.sx = SITE_W'(x + nb_dx[sel]);
                            o.sy = SITE_W'(y + nb_dy[sel]);
                            o.sz = SITE_W'(z + nb_dz[sel]);
                        end
                    end
                end
                if (!found)
                    o.st = ST_NO_SITE;
            end
            OP_BORDER:
            begin
                for (int i = 0; i < N_FACE; i++)
                begin
                    if (kind_at(x + nb_dx[i], y + nb_dy[i], z + nb_dz[i]) == KIND_BORDER)
                        o.touch = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic queue_req(logic [2:0] op, int x, int y, int z, logic [KIND_W-1:0] kind,
                             logic [PICK_W-1:0] pk);
        lattice_req_t r;
        r.op = op;
        r.x = POS_W'(x);
        r.y = POS_W'(y);
        r.z = POS_W'(z);
        r.kind = kind;
        r.pick = pk;
        pending_reqs.insert(pending_reqs.size(), r);
        unaccepted++;
    endtask

    function automatic int pick_coord(int mode, int lim, int focus);
        if (mode < 12)
            return $urandom;
        if (mode < 70)
            return focus + int'($urandom_range(2)) - 1;
        return int'($urandom_range(lim + 1)) - 1;
    endfunction

    // requests cluster around a moving focus so neighbourhoods fill up
    task automatic queue_random_reqs(int count);
        int ex = clip(lat_size[CFG_SIZE_X]);
        int ey = clip(lat_size[CFG_SIZE_Y]);
        int ez = clip(lat_size[CFG_SIZE_Z]);
        int fx;
        int fy;
        int fz;
        int roll;
        int mode;
        logic [2:0] op;
        for (int k = 0; k < count; k++)
        begin
            if (k % 8 == 0)
            begin
                fx = $urandom_range(ex);
                fy = $urandom_range(ey);
                fz = $urandom_range(ez);
            end
            roll = $urandom_range(99);
            if (roll < 30)
                op = OP_PLACE;
            else if (roll < 50)
                op = OP_FIND;
            else if (roll < 65)
                op = OP_QUERY;
            else if (roll < 80)
                op = OP_REMOVE;
            else if (roll < 95)
                op = OP_BORDER;
            else
                op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            mode = $urandom_range(99);
            queue_req(op, pick_coord(mode, ex, fx), pick_coord(mode, ey, fy),
                      pick_coord(mode, ez, fz), KIND_W'($urandom), PICK_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (unaccepted != 0 || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [SIZE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        lat_size[idx] = val;
    endtask

    task automatic set_sizes(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                             logic [SIZE_W-1:0] sz);
        wait_drained();
        write_size(CFG_SIZE_X, sx);
        write_size(CFG_SIZE_Y, sy);
        write_size(CFG_SIZE_Z, sz);
        settings_used++;
    endtask

    task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_rsps.insert(expected_rsps.size(), apply_request(req_now));
                op_seen[req_now.op]++;
                unaccepted--;
                slot_free = 1'b1;
            end
            else
                slot_free = !in_valid;
            if (slot_free)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 27))
                begin
                    req_now = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    opcode <= req_now.op;
                    pos_x <= req_now.x;
                    pos_y <= req_now.y;
                    pos_z <= req_now.z;
                    occupant_kind <= req_now.kind;
                    pick <= req_now.pick;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t: result with no request, expected none, actual kind %0d status %0d",
                                 $time, voxel_kind, status);
                end
                else
                begin
                    rsp_due = expected_rsps.pop_front();
                    results_seen++;
                    if (rsp_due.st == ST_NO_SITE)
                        finds_no_site++;
                    if (rsp_due.st == ST_BORDER || rsp_due.touch)
                        border_hits++;
                    check_field("voxel_kind", 16'(rsp_due.vkind), 16'(voxel_kind));
                    check_field("status", 16'(rsp_due.st), 16'(status));
                    check_field("site_x", 16'(rsp_due.sx), {10'b0, site_x});
                    check_field("site_y", 16'(rsp_due.sy), {10'b0, site_y});
                    check_field("site_z", 16'(rsp_due.sz), {10'b0, site_z});
                    check_field("touches_border", 16'(rsp_due.touch), 16'(touches_border));
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
        end
    end

    initial
    begin
        for (int a = 0; a < DEPTH; a++)
            occ_model[a] = '0;
        for (int o = 0; o < 8; o++)
            op_seen[o] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: sphere centre 15, radius 15
        queue_req(OP_QUERY, 15, 15, 15, 3'd1, 16'h0000);
        queue_req(OP_PLACE, 15, 15, 15, 3'd7, 16'h0000);
        queue_req(OP_PLACE, 15, 15, 15, 3'd3, 16'h0000);
        queue_req(OP_QUERY, 15, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_REMOVE, 15, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_REMOVE, 15, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_PLACE, 15, 15, 16, 3'd0, 16'h0000);
        queue_req(OP_QUERY, 0, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_QUERY, -1, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_QUERY, 31, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_QUERY, -64, -64, -64, 3'd0, 16'h0000);
        queue_req(OP_QUERY, 63, 63, 63, 3'd0, 16'h0000);
        queue_req(OP_PLACE, 0, 0, 0, 3'd5, 16'h0000);
        queue_req(OP_REMOVE, 0, 0, 0, 3'd0, 16'h0000);
        queue_req(OP_BORDER, 0, 15, 15, 3'd0, 16'h0000);
        queue_req(OP_BORDER, 15, 15, 15, 3'd0, 16'h0000);
        for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
            queue_req(3'(o), 15, 15, 15, 3'd7, 16'hFFFF);
        // wall in one voxel on all faces so the search falls back to edges
        for (int i = 0; i < N_FACE; i++)
            queue_req(OP_PLACE, 10 + nb_dx[i], 10 + nb_dy[i], 10 + nb_dz[i], 3'(i + 1), 16'h0);
        queue_req(OP_FIND, 10, 10, 10, 3'd0, 16'hFFFF);
        queue_req(OP_FIND, 15, 15, 15, 3'd0, 16'h0000);
        queue_random_reqs(50);

        set_sizes(6'd5, 6'd5, 6'd5);
        queue_random_reqs(80);
        set_sizes(6'd3, 6'd3, 6'd3);
        queue_random_reqs(40);
        set_sizes(6'd1, 6'd1, 6'd1);
        queue_random_reqs(25);
        set_sizes(6'd0, 6'd9, 6'd33);
        queue_random_reqs(20);

        set_sizes(6'd63, 6'd63, 6'd63);
        calm = 1'b1;
        queue_random_reqs(45);
        wait_drained();
        queue_random_reqs(45);
        wait_drained();
        calm = 1'b0;

        set_sizes(6'd32, 6'd7, 6'd20);
        queue_random_reqs(60);
        for (int p = 0; p < 2; p++)
        begin
            set_sizes(SIZE_W'($urandom_range(63)), SIZE_W'($urandom_range(63)),
                      SIZE_W'($urandom_range(63)));
            queue_random_reqs(30);
        end

        wait_drained();
        repeat (60) @(posedge clk);

        $display("checked %0d results over %0d lattice size settings", results_seen,
                 settings_used);
        $display("finds %0d (%0d with no free site), border outcomes %0d, unused opcodes %0d",
                 op_seen[OP_FIND], finds_no_site, border_hits,
                 op_seen[5] + op_seen[6] + op_seen[7]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
